>>> src/dws_pkg.sv
package dws_pkg;

  localparam int MAX_WORD_DEF    = 32;
  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCMP,
    ST_RESOLVE,
    ST_ERD,
    ST_EOUT,
    ST_DELIM
  } state_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic start;    // load match flags from length compare
    logic cmp;      // fold one character compare into match flags
    logic word_ok;  // pending word is nonempty and not truncated
    logic key_wr;   // table write beat on the key side
  } dws_ctl_t;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

endpackage

>>> src/dws_ram.sv
module dws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/dws_cell.sv
module dws_cell import dws_pkg::*; #(
  parameter int MAX_WORD    = MAX_WORD_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int IDX         = 0,
  parameter int PW          = $clog2(MAX_WORD),
  parameter int LW          = $clog2(MAX_WORD + 1),
  parameter int EW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  dws_ctl_t      ctl,
  input  logic [4:0]    entry,
  input  logic [5:0]    position,
  input  logic [7:0]    character,
  input  logic [5:0]    entry_count,
  input  logic [LW-1:0] word_len,
  input  logic [7:0]    word_char,
  input  logic [PW-1:0] rd_addr,
  input  logic          hit_in_v,
  input  logic [EW-1:0] hit_in_idx,
  output logic          hit_out_v,
  output logic [EW-1:0] hit_out_idx
);

  logic [LW-1:0] key_len;
  logic          match;
  logic [7:0]    key_rd;
  logic          sel;
  logic          char_we;

  assign sel     = ctl.key_wr && ({2'b00, entry} == 7'(IDX));
  assign char_we = sel && (character != 8'd0) && ({1'b0, position} < 7'(MAX_WORD));

  dws_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_key (
    .clk   (clk),
    .we    (char_we),
    .waddr (position[PW-1:0]),
    .wdata (character),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      match   <= 1'b0;
    end else begin
      if (sel && character == 8'd0) begin
        key_len <= ({1'b0, position} > 7'(MAX_WORD)) ? LW'(MAX_WORD) : LW'(position);
      end
      if (ctl.start) begin
        match <= ctl.word_ok && (key_len == word_len) &&
                 (7'(IDX) < {1'b0, entry_count});
      end else if (ctl.cmp) begin
        match <= match && (key_rd == word_char);
      end
    end
  end

  // later entries override earlier ones
  assign hit_out_v   = match || hit_in_v;
  assign hit_out_idx = match ? EW'(IDX) : hit_in_idx;

endmodule

>>> src/dictionary_word_substitution.sv
// Streaming word replacement. Text enters one character per beat; runs of
// ASCII letters and digits are collected into a word of up to MAX_WORD
// characters (extra letters are dropped and flag the word as truncated).
// A non-word character or a flush beat ends the word: the word is compared
// against every key in use by a row of one cell per table entry, each
// cell owning its key memory, stepping through the word a character at
// a time with a read state and a compare state, then the replacement
// (last matching entry) or the word itself is sent out one character per
// beat, followed by the ending character if a character ended the word.
// Input is not ready from a word end until its output has been sent.
// Table writes are taken as input beats with kind 0.
module dictionary_word_substitution import dws_pkg::*; #(
  parameter int MAX_WORD    = MAX_WORD_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic       side,
  input  logic [4:0] entry,
  input  logic [5:0] position,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last,
  output logic       truncated
);

  localparam int PW = $clog2(MAX_WORD);
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t        state, state_next;
  logic [5:0]    entry_count;
  logic [LW-1:0] word_length;
  logic          word_overflow;
  logic [LW-1:0] idx;
  logic [LW-1:0] emit_len;
  logic          from_rep;
  logic [EW-1:0] hit_idx;
  logic          has_delim;
  logic [7:0]    delim;
  logic          trunc;
  logic [LW-1:0] rep_len [MAX_ENTRIES];

  logic          accept;
  logic          tbl_wr;
  logic          word_end;
  logic [LW-1:0] idx_inc;
  logic [LW-1:0] res_len;
  logic [7:0]    word_rd;
  logic [7:0]    rep_rd;
  logic [6:0]    entry_ext;
  dws_ctl_t      ctl;

  logic          hv [MAX_ENTRIES + 1];
  logic [EW-1:0] hi [MAX_ENTRIES + 1];

  assign accept    = in_valid && in_ready;
  assign entry_ext = {2'b00, entry};
  assign tbl_wr    = accept && kind == KIND_WRITE && entry_ext < 7'(MAX_ENTRIES);
  assign word_end  = accept && ((kind == KIND_CHAR && !is_word_char(character)) ||
                                kind == KIND_FLUSH);
  assign idx_inc   = idx + 1'b1;
  assign res_len   = hv[MAX_ENTRIES] ? rep_len[hi[MAX_ENTRIES]] : word_length;

  assign ctl.start   = word_end;
  assign ctl.cmp     = (state == ST_MCMP);
  assign ctl.word_ok = (word_length != '0) && !word_overflow;
  assign ctl.key_wr  = tbl_wr && !side;

  dws_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word (
    .clk   (clk),
    .we    (accept && kind == KIND_CHAR && is_word_char(character) &&
            word_length < LW'(MAX_WORD)),
    .waddr (word_length[PW-1:0]),
    .wdata (character),
    .raddr (idx[PW-1:0]),
    .rdata (word_rd)
  );

  dws_ram #(.WIDTH(8), .DEPTH((1 << EW) * (1 << PW))) u_rep (
    .clk   (clk),
    .we    (tbl_wr && side && character != 8'd0 && {1'b0, position} < 7'(MAX_WORD)),
    .waddr ({entry_ext[EW-1:0], position[PW-1:0]}),
    .wdata (character),
    .raddr ({hit_idx, idx[PW-1:0]}),
    .rdata (rep_rd)
  );

  assign hv[0] = 1'b0;
  assign hi[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    dws_cell #(
      .MAX_WORD(MAX_WORD), .MAX_ENTRIES(MAX_ENTRIES), .IDX(g),
      .PW(PW), .LW(LW), .EW(EW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .entry       (entry),
      .position    (position),
      .character   (character),
      .entry_count (entry_count),
      .word_len    (word_length),
      .word_char   (word_rd),
      .rd_addr     (idx[PW-1:0]),
      .hit_in_v    (hv[g]),
      .hit_in_idx  (hi[g]),
      .hit_out_v   (hv[g+1]),
      .hit_out_idx (hi[g+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (word_end) begin
          state_next = (word_length != '0) ? ST_MRD : ST_RESOLVE;
        end
      end
      ST_MRD:  state_next = ST_MCMP;
      ST_MCMP: state_next = (idx_inc == word_length) ? ST_RESOLVE : ST_MRD;
      ST_RESOLVE: begin
        if (res_len != '0) begin
          state_next = ST_ERD;
        end else begin
          state_next = has_delim ? ST_DELIM : ST_IDLE;
        end
      end
      ST_ERD: state_next = ST_EOUT;
      ST_EOUT: begin
        if (out_ready) begin
          if (idx_inc != emit_len) begin
            state_next = ST_ERD;
          end else begin
            state_next = has_delim ? ST_DELIM : ST_IDLE;
          end
        end
      end
      ST_DELIM: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_char  = delim;
    last      = 1'b0;
    truncated = trunc;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EOUT: begin
        out_valid = 1'b1;
        out_char  = from_rep ? rep_rd : word_rd;
        last      = (idx_inc == emit_len) && !has_delim;
      end
      ST_DELIM: begin
        out_valid = 1'b1;
        last      = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      word_length   <= '0;
      word_overflow <= 1'b0;
      idx           <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rep_len[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        entry_count <= cfg_data;
      end
      if (tbl_wr && side && character == 8'd0) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (entry_ext == 7'(i)) begin
            rep_len[i] <= ({1'b0, position} > 7'(MAX_WORD)) ? LW'(MAX_WORD)
                                                              : LW'(position);
          end
        end
      end
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept && kind == KIND_CHAR && is_word_char(character)) begin
            if (word_length < LW'(MAX_WORD)) begin
              word_length <= word_length + 1'b1;
            end else begin
              word_overflow <= 1'b1;
            end
          end
        end
        ST_MCMP: idx <= idx_inc;
        ST_RESOLVE: begin
          idx           <= '0;
          word_length   <= '0;
          word_overflow <= 1'b0;
        end
        ST_EOUT: begin
          if (out_ready) begin
            idx <= idx_inc;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // payload of the current word end
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && word_end) begin
      has_delim <= (kind == KIND_CHAR);
      delim     <= character;
      trunc     <= word_overflow;
    end
    if (state == ST_RESOLVE) begin
      from_rep <= hv[MAX_ENTRIES];
      hit_idx  <= hi[MAX_ENTRIES];
      emit_len <= res_len;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dws_pkg::*;

  localparam int WLIM = 32;
  localparam int ELIM = 32;
  localparam int NTAB = 16;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0] kind;
    logic       side;
    logic [4:0] entry;
    logic [5:0] position;
    logic [7:0] character;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       trunc;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic side = 1'b0;
  logic [4:0] entry = '0;
  logic [5:0] position = '0;
  logic [7:0] character = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_char;
  logic last;
  logic truncated;

  dictionary_word_substitution u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .side(side),
    .entry(entry), .position(position), .character(character),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .last(last), .truncated(truncated)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [7:0] pend_word [WLIM];
  int         pend_len;
  logic       pend_ovf;
  logic [7:0] key_mem [ELIM][WLIM];
  int         key_len [ELIM];
  logic [7:0] rep_mem [ELIM][WLIM];
  int         rep_len [ELIM];
  int         used_entries;

  text_beat_t pending_beats[$];
  out_beat_t  expected_chars[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;       // no idling near the end
  bit gate_in = 0;     // sender hold while draining
  int hold_off = 0;    // long receiver stall request

  function automatic bit word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void push_char(logic [7:0] c, logic t);
    out_beat_t b;
    b.ch = c; b.last = 1'b0; b.trunc = t;
    expected_chars.push_back(b);
  endfunction

  function automatic void emit_pending(logic t);
    int hit;
    int lim;
    bit same;
    hit = -1;
    lim = used_entries > ELIM ? ELIM : used_entries;
    if (pend_len > 0 && !pend_ovf)
      for (int e = 0; e < lim; e++) begin
        if (key_len[e] != pend_len) continue;
        same = 1;
        for (int i = 0; i < pend_len; i++)
          if (key_mem[e][i] !== pend_word[i]) same = 0;
        if (same) hit = e;
      end
    if (hit >= 0)
      for (int i = 0; i < rep_len[hit]; i++) push_char(rep_mem[hit][i], t);
    else
      for (int i = 0; i < pend_len; i++) push_char(pend_word[i], t);
    pend_len = 0;
    pend_ovf = 0;
  endfunction

  function automatic void predict_beat(text_beat_t b);
    int n0;
    logic t;
    n0 = expected_chars.size();
    case (b.kind)
      KIND_WRITE: begin
        if (b.character == 0) begin
          if (b.side) rep_len[b.entry] = b.position > WLIM ? WLIM : b.position;
          else key_len[b.entry] = b.position > WLIM ? WLIM : b.position;
        end else if (b.position < WLIM) begin
          if (b.side) rep_mem[b.entry][b.position] = b.character;
          else key_mem[b.entry][b.position] = b.character;
        end
      end
      KIND_CHAR: begin
        if (word_char(b.character)) begin
          if (pend_len < WLIM) begin
            pend_word[pend_len] = b.character;
            pend_len++;
          end else pend_ovf = 1;
        end else begin
          t = pend_ovf;
          emit_pending(t);
          push_char(b.character, t);
        end
      end
      KIND_FLUSH: emit_pending(pend_ovf);
      default: ;
    endcase
    if (expected_chars.size() > n0)
      expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    text_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (!quiet && in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        // idle burst
        in_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0 && !gate_in) begin
        b = pending_beats.pop_front();
        predict_beat(b);
        in_valid <= 1'b1;
        {kind, side, entry, position, character} <= b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat ch=%h last=%b trunc=%b",
                                   out_char, last, truncated);
      end else begin
        e = expected_chars.pop_front();
        if (e.ch !== out_char || e.last !== last || e.trunc !== truncated) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp ch=%h last=%b trunc=%b got ch=%h last=%b trunc=%b",
                     e.ch, e.last, e.trunc, out_char, last, truncated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // stimulus helpers
  function automatic text_beat_t mk(logic [1:0] k, logic s, logic [4:0] e,
                                    logic [5:0] p, logic [7:0] c);
    text_beat_t b;
    b.kind = k; b.side = s; b.entry = e; b.position = p; b.character = c;
    return b;
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(48, 57));
      1: return 8'($urandom_range(65, 90));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic logic [7:0] rand_delim();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (word_char(c));
    return c;
  endfunction

  // words from a small alphabet so keys hit often
  logic [7:0] dict_word [ELIM][WLIM];
  int         dict_len [ELIM];

  task automatic write_entry(int e, bit s, int len, bit from_dict);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = from_dict ? dict_word[e][i] : rand_word_char();
      if (!s) dict_word[e][i] = c;
      pending_beats.push_back(mk(KIND_WRITE, s, 5'(e), 6'(i), c));
    end
    pending_beats.push_back(mk(KIND_WRITE, s, 5'(e), 6'(len), 8'h00));
  endtask

  task automatic load_table(int n);
    int len;
    for (int e = 0; e < n; e++) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(1, WLIM) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) dict_word[e][i] = 8'("a" + $urandom_range(0, 2));
      dict_len[e] = len;
      write_entry(e, 0, len, 1);
      write_entry(e, 1, $urandom_range(0, 9) == 0 ? WLIM : $urandom_range(0, 5), 0);
    end
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0);
    gate_in = 1;
    @(posedge clk);
    while (in_valid || expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    gate_in = 0;
  endtask

  task automatic set_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= 6'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    used_entries = v;
  endtask

  task automatic random_text(int n, int ntab);
    int e, len;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: pending_beats.push_back(mk(KIND_FLUSH, 1'($urandom), 5'($urandom), 6'($urandom), 8'($urandom)));
        1: pending_beats.push_back(mk(KIND_NONE, 1'($urandom), 5'($urandom), 6'($urandom), 8'($urandom)));
        2, 3, 4, 5: pending_beats.push_back(mk(KIND_CHAR, 0, 5'($urandom), 6'($urandom), rand_delim()));
        6, 7, 8, 9, 10, 11: begin
          // a known key word
          e = $urandom_range(0, ntab - 1);
          for (int i = 0; i < dict_len[e]; i++)
            pending_beats.push_back(mk(KIND_CHAR, 1'($urandom), 5'($urandom), 6'($urandom),
                                       dict_word[e][i]));
          k += dict_len[e];
        end
        12: begin
          len = $urandom_range(33, 36);
          for (int i = 0; i < len; i++)
            pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, rand_word_char()));
          k += len;
        end
        default: pending_beats.push_back(mk(KIND_CHAR, 0, 5'($urandom), 6'($urandom),
                                            $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 2))
                                                                  : rand_word_char()));
      endcase
    end
  endtask

  initial begin
    int cnts [4];
    pend_len = 0; pend_ovf = 0; used_entries = 0;
    for (int e = 0; e < ELIM; e++) begin
      key_len[e] = 0; rep_len[e] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes
    pending_beats.push_back(mk(KIND_FLUSH, 0, 0, 0, 0));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, 8'h20));
    pending_beats.push_back(mk(KIND_CHAR, 1, 31, 63, "0"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "9"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "A"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "Z"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "a"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "z"));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, 8'hFF));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, "z"));
    pending_beats.push_back(mk(KIND_NONE, 1, 31, 63, 8'hFF));
    pending_beats.push_back(mk(KIND_FLUSH, 1, 31, 63, 8'hFF));
    pending_beats.push_back(mk(KIND_CHAR, 0, 0, 0, 8'h00));
    // ignored writes: nonzero characters at and beyond the word limit, on both sides
    pending_beats.push_back(mk(KIND_WRITE, 0, 31, 63, 8'hFF));
    pending_beats.push_back(mk(KIND_WRITE, 1, 31, 32, 8'h41));
    drain();

    load_table(NTAB);
    drain();

    cnts[0] = 63; cnts[1] = 32; cnts[2] = 0; cnts[3] = 5;
    for (int ph = 0; ph < 4; ph++) begin
      set_count(cnts[ph]);
      if (ph == 3) quiet = 1;
      random_text(60, NTAB);
      pending_beats.push_back(mk(KIND_FLUSH, 0, 0, 0, 0));
      if (ph == 1) begin
        // long receiver hold while the sender keeps offering
        wait (pending_beats.size() < 80);
        hold_off = 600;
      end
      drain();
    end
    set_count(1);
    repeat (50) @(posedge clk);

    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
